>>> hdl/nice_number_axis_scaler_top_assert.svh
// ----------------------------------------------------------------------------
// nice_number_axis_scaler_top_assert.svh
// assertion macros shared by the axis scaler rtl
// ----------------------------------------------------------------------------
`ifndef NICE_NUMBER_AXIS_SCALER_TOP_ASSERT_SVH
`define NICE_NUMBER_AXIS_SCALER_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define NNAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define NNAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/nnas_pkg.sv
// ----------------------------------------------------------------------------
// nnas_pkg
// types, constants and table functions of the nice number axis scaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnas_pkg;

	localparam int IDX_W     = 37;
	localparam int TM_W      = 3;
	localparam int TE_W      = 5;
	localparam int TCFG_W    = 6;
	localparam int T_W       = 9;
	localparam int NDEC      = 15;
	localparam int P10_W     = 64;

	localparam logic [TM_W-1:0] TM_ONE  = 3'd1;
	localparam logic [TM_W-1:0] TM_TWO  = 3'd2;
	localparam logic [TM_W-1:0] TM_FIVE = 3'd5;

	// values that ride along with a transaction through the divider
	typedef struct packed {
		logic [TM_W-1:0]        tm;
		logic signed [TE_W-1:0] te;
		logic                   err;
		logic                   lo_neg;
		logic                   hi_pos;
	} nnas_side_t;

	// tick spacing choice for one nice range mantissa and tick count
	typedef struct packed {
		logic [TM_W-1:0] tm;
		logic [1:0]      k;
		logic            up;
	} nnas_tsel_t;

	// powers of ten
	function automatic logic [P10_W-1:0] pow10(input logic [4:0] e);
		logic [P10_W-1:0] p;
		case (e)
			5'd0:    p = 64'd1;
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			5'd16:   p = 64'd10000000000000000;
			default: p = 64'd0;
		endcase
		return p;
	endfunction

	// smallest k with rm*10^k >= t, then round the ratio with 1.5 / 3 / 7
	function automatic nnas_tsel_t tick_sel(input logic [TM_W-1:0] rm,
			input logic [T_W-1:0] t);
		nnas_tsel_t       r;
		logic [12:0]      x0;
		logic [12:0]      x1;
		logic [12:0]      x2;
		logic [12:0]      x3;
		logic [12:0]      x;
		logic [12:0]      t13;
		logic [13:0]      t14;
		x0  = 13'(rm);
		x1  = 13'(rm) * 13'd10;
		x2  = 13'(rm) * 13'd100;
		x3  = 13'(rm) * 13'd1000;
		t13 = 13'(t);
		t14 = 14'(t);
		if (x0 >= t13) begin
			r.k = 2'd0; x = x0;
		end else if (x1 >= t13) begin
			r.k = 2'd1; x = x1;
		end else if (x2 >= t13) begin
			r.k = 2'd2; x = x2;
		end else begin
			r.k = 2'd3; x = x3;
		end
		r.up = 1'b0;
		if ((14'(x) << 1) < (14'd3 * t14)) begin
			r.tm = TM_ONE;
		end else if (14'(x) < (14'd3 * t14)) begin
			r.tm = TM_TWO;
		end else if (14'(x) < (14'd7 * t14)) begin
			r.tm = TM_FIVE;
		end else begin
			r.tm = TM_ONE;
			r.up = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> hdl/nice_number_axis_scaler_top.sv
// Axis scaler: takes a data minimum and maximum and returns a 1-2-5 tick
// spacing (mantissa times a power of ten) with the floor tick index of the
// minimum and the ceiling tick index of the maximum. One range is accepted
// every clock cycle unless the output stalls; the pipeline has five stages
// of range and spacing selection, one divider stage per quotient bit
// (DATA_WIDTH + 9 of them), and the output register. The whole pipeline
// holds while a finished result waits on out_ready.
// ----------------------------------------------------------------------------
// nice_number_axis_scaler_top
// pipelined nice number axis scaling with tick index division
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nice_number_axis_scaler_top_assert.svh"

module nice_number_axis_scaler_top
	import nnas_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int MAX_TICKS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [TCFG_W-1:0]            cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] data_min,
	input  logic signed [DATA_WIDTH-1:0] data_max,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [TM_W-1:0]              tick_mantissa,
	output logic signed [TE_W-1:0]       tick_exponent,
	output logic signed [IDX_W-1:0]      low_tick_index,
	output logic signed [IDX_W-1:0]      high_tick_index,
	output logic                         order_error
);

	localparam int SPAN_W = DATA_WIDTH + 1;
	localparam int MAG_W  = DATA_WIDTH;
	localparam int NUM_W  = DATA_WIDTH + 9;
	localparam int DEN_W  = DATA_WIDTH + 5;
	localparam int QW     = NUM_W + 1;

	logic en;

	// tick count register
	logic [TCFG_W-1:0] tcfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q <= TCFG_W'(5);
		end else if (cfg_we) begin
			tcfg_q <= cfg_wdata;
		end
	end

	// whole pipeline advances unless the output holds an untaken result
	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: order check, equal bump, span, tick clamp
	logic                     v_s1, err_s1;
	logic signed [SPAN_W-1:0] lo_s1, hi_s1;
	logic [SPAN_W-1:0]        span_s1;
	logic [T_W-1:0]           t_s1;
	logic signed [SPAN_W-1:0] lo_c, hi_c;
	logic [T_W-1:0]           t_c;

	always_comb begin
		lo_c = SPAN_W'(data_min);
		hi_c = SPAN_W'(data_max);
		if (data_min == data_max) begin
			hi_c = hi_c + SPAN_W'(1);
		end
		t_c = T_W'(tcfg_q);
		if (t_c == '0) begin
			t_c = T_W'(1);
		end else if (t_c > T_W'(MAX_TICKS)) begin
			t_c = T_W'(MAX_TICKS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo_c;
			hi_s1   <= hi_c;
			span_s1 <= SPAN_W'(hi_c - lo_c);
			err_s1  <= data_min > data_max;
			t_s1    <= t_c;
		end
	end

	// stage 2: decade of the span
	logic                     v_s2, err_s2;
	logic signed [SPAN_W-1:0] lo_s2, hi_s2;
	logic [SPAN_W-1:0]        span_s2;
	logic [T_W-1:0]           t_s2;
	logic [4:0]               re_s2;
	logic [4:0]               re_c;

	always_comb begin
		re_c = '0;
		for (int i = 1; i <= NDEC; i++) begin
			if (P10_W'(span_s1) >= pow10(5'(i))) begin
				re_c = re_c + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			span_s2 <= span_s1;
			err_s2  <= err_s1;
			t_s2    <= t_s1;
			re_s2   <= re_c;
		end
	end

	// stage 3: round the span up to 1, 2, 5 or 10 times the decade
	logic                     v_s3, err_s3;
	logic signed [SPAN_W-1:0] lo_s3, hi_s3;
	logic [T_W-1:0]           t_s3;
	logic [4:0]               re_s3;
	logic [TM_W-1:0]          rm_s3;
	logic [P10_W-1:0]         p_c, sp_c;
	logic [4:0]               re3_c;
	logic [TM_W-1:0]          rm_c;

	always_comb begin
		p_c   = pow10(re_s2);
		sp_c  = P10_W'(span_s2);
		re3_c = re_s2;
		if (sp_c <= p_c) begin
			rm_c = TM_ONE;
		end else if (sp_c <= (p_c << 1)) begin
			rm_c = TM_TWO;
		end else if (sp_c <= ((p_c << 2) + p_c)) begin
			rm_c = TM_FIVE;
		end else begin
			rm_c  = TM_ONE;
			re3_c = re_s2 + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3  <= lo_s2;
			hi_s3  <= hi_s2;
			err_s3 <= err_s2;
			t_s3   <= t_s2;
			re_s3  <= re3_c;
			rm_s3  <= rm_c;
		end
	end

	// stage 4: tick spacing and magnitudes of the bounds
	logic              v_s4, err_s4, lo_neg_s4, hi_pos_s4, hi_neg_c;
	logic [TM_W-1:0]   tm_s4;
	logic signed [5:0] te_s4;
	logic [MAG_W-1:0]  mag_lo_s4, mag_hi_s4;
	nnas_tsel_t        sel_c;

	assign sel_c    = tick_sel(rm_s3, t_s3);
	assign hi_neg_c = hi_s3 < 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4    <= err_s3;
			tm_s4     <= sel_c.tm;
			te_s4     <= $signed(6'(re_s3) - 6'(sel_c.k) + 6'(sel_c.up));
			lo_neg_s4 <= lo_s3 < 0;
			hi_pos_s4 <= hi_s3 > 0;
			mag_lo_s4 <= (lo_s3 < 0) ? MAG_W'(-lo_s3) : MAG_W'(lo_s3);
			mag_hi_s4 <= hi_neg_c ? MAG_W'(-hi_s3) : MAG_W'(hi_s3);
		end
	end

	// stage 5: scale numerators for negative exponents, build divisor
	// the scale factor is at most 1000, so it fits ten bits
	logic              v_s5;
	logic [NUM_W-1:0]  num_lo_s5, num_hi_s5;
	logic [DEN_W-1:0]  den_s5;
	nnas_side_t        side_s5;
	logic [4:0]        sc_c, dp_c;
	logic [9:0]        fac_c;

	always_comb begin
		sc_c  = (te_s4 < 0) ? 5'(-te_s4) : 5'd0;
		dp_c  = (te_s4 > 0) ? 5'(te_s4) : 5'd0;
		fac_c = 10'(pow10(sc_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_lo_s5      <= NUM_W'(mag_lo_s4) * NUM_W'(fac_c);
			num_hi_s5      <= NUM_W'(mag_hi_s4) * NUM_W'(fac_c);
			den_s5         <= DEN_W'(tm_s4) * DEN_W'(pow10(dp_c));
			side_s5.tm     <= tm_s4;
			side_s5.te     <= TE_W'(te_s4);
			side_s5.err    <= err_s4;
			side_s5.lo_neg <= lo_neg_s4;
			side_s5.hi_pos <= hi_pos_s4;
		end
	end

	// divider pipeline
	logic             dv_valid, rem_lo_nz, rem_hi_nz;
	logic [NUM_W-1:0] quo_lo, quo_hi;
	nnas_side_t       dv_side;

	nnas_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num_a    (num_lo_s5),
		.num_b    (num_hi_s5),
		.den      (den_s5),
		.side_in  (side_s5),
		.out_valid(dv_valid),
		.quo_a    (quo_lo),
		.rem_a_nz (rem_lo_nz),
		.quo_b    (quo_hi),
		.rem_b_nz (rem_hi_nz),
		.side_out (dv_side)
	);

	// floor and ceiling sign fix
	logic signed [QW-1:0] qlo_c, qhi_c;

	always_comb begin
		if (dv_side.lo_neg) begin
			qlo_c = -($signed(QW'(quo_lo)) + $signed(QW'(rem_lo_nz)));
		end else begin
			qlo_c = $signed(QW'(quo_lo));
		end
		if (dv_side.hi_pos) begin
			qhi_c = $signed(QW'(quo_hi)) + $signed(QW'(rem_hi_nz));
		end else begin
			qhi_c = -$signed(QW'(quo_hi));
		end
	end

	// output register
	logic [TM_W-1:0]         tm_q;
	logic signed [TE_W-1:0]  te_q;
	logic signed [IDX_W-1:0] lo_idx_q, hi_idx_q;
	logic                    err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= dv_side.err;
			if (dv_side.err) begin
				tm_q     <= '0;
				te_q     <= '0;
				lo_idx_q <= '0;
				hi_idx_q <= '0;
			end else begin
				tm_q     <= dv_side.tm;
				te_q     <= dv_side.te;
				lo_idx_q <= IDX_W'(qlo_c);
				hi_idx_q <= IDX_W'(qhi_c);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign tick_mantissa   = tm_q;
	assign tick_exponent   = te_q;
	assign low_tick_index  = lo_idx_q;
	assign high_tick_index = hi_idx_q;
	assign order_error     = err_q;

	// checks
	`NNAS_ASSERT_IMP(a_stall_holds_input, out_valid && !out_ready, !in_ready, "input taken during output stall")
	`NNAS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_s1, "accepted transaction lost at entry")
	`NNAS_ASSERT_IMP(a_mantissa_nice, out_valid && !order_error, tick_mantissa == TM_ONE || tick_mantissa == TM_TWO || tick_mantissa == TM_FIVE, "mantissa not 1, 2 or 5")
	`NNAS_ASSERT_IMP(a_error_zeroes, out_valid && order_error, tick_mantissa == '0 && tick_exponent == '0 && low_tick_index == '0 && high_tick_index == '0, "order error with nonzero fields")

endmodule

>>> hdl/nnas_div.sv
// ----------------------------------------------------------------------------
// nnas_div
// pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnas_div
	import nnas_pkg::*;
#(
	parameter int NUM_W = 41,
	parameter int DEN_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	input  nnas_side_t       side_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo_a,
	output logic             rem_a_nz,
	output logic [NUM_W-1:0] quo_b,
	output logic             rem_b_nz,
	output nnas_side_t       side_out
);

	// stage arrays, entry 0 is the divider input
	logic [DEN_W-1:0] rem_a_s [NUM_W+1];
	logic [DEN_W-1:0] rem_b_s [NUM_W+1];
	logic [NUM_W-1:0] nq_a_s  [NUM_W+1];
	logic [NUM_W-1:0] nq_b_s  [NUM_W+1];
	logic [DEN_W-1:0] den_s   [NUM_W+1];
	nnas_side_t       side_s  [NUM_W+1];
	logic             v_s     [NUM_W+1];

	assign rem_a_s[0] = '0;
	assign rem_b_s[0] = '0;
	assign nq_a_s[0]  = num_a;
	assign nq_b_s[0]  = num_b;
	assign den_s[0]   = den;
	assign side_s[0]  = side_in;
	assign v_s[0]     = in_valid;

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [DEN_W:0] trial_a;
		logic [DEN_W:0] trial_b;
		logic           ge_a;
		logic           ge_b;

		// shift in the next numerator bit and try a subtract
		always_comb begin
			trial_a = {rem_a_s[g], nq_a_s[g][NUM_W-1]};
			trial_b = {rem_b_s[g], nq_b_s[g][NUM_W-1]};
			ge_a    = trial_a >= {1'b0, den_s[g]};
			ge_b    = trial_b >= {1'b0, den_s[g]};
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[g+1] <= ge_a ? DEN_W'(trial_a - {1'b0, den_s[g]}) : DEN_W'(trial_a);
				rem_b_s[g+1] <= ge_b ? DEN_W'(trial_b - {1'b0, den_s[g]}) : DEN_W'(trial_b);
				nq_a_s[g+1]  <= {nq_a_s[g][NUM_W-2:0], ge_a};
				nq_b_s[g+1]  <= {nq_b_s[g][NUM_W-2:0], ge_b};
				den_s[g+1]   <= den_s[g];
				side_s[g+1]  <= side_s[g];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo_a     = nq_a_s[NUM_W];
	assign quo_b     = nq_b_s[NUM_W];
	assign rem_a_nz  = |rem_a_s[NUM_W];
	assign rem_b_nz  = |rem_b_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the nice number axis scaler: a predictor computes
// the 1-2-5 tick spacing and tick indices of every sent range, and each
// result is compared field by field in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
	import nnas_pkg::*;
();

	localparam int DW        = 32;
	localparam int MAXT      = 32;
	localparam int LATENCY   = DW + 15;
	localparam int N_RANDOM  = 270;

	typedef struct packed {
		logic [TM_W-1:0]        mant;
		logic signed [TE_W-1:0] expo;
		logic signed [IDX_W-1:0] lo_idx;
		logic signed [IDX_W-1:0] hi_idx;
		logic                   err;
	} scale_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [TCFG_W-1:0]      cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [DW-1:0]   data_min;
	logic signed [DW-1:0]   data_max;
	logic                   out_valid;
	logic                   out_ready;
	logic [TM_W-1:0]        tick_mantissa;
	logic signed [TE_W-1:0] tick_exponent;
	logic signed [IDX_W-1:0] low_tick_index;
	logic signed [IDX_W-1:0] high_tick_index;
	logic                   order_error;

	logic [TCFG_W-1:0] ticks_reg;
	scale_t            scale_q[$];
	int                mismatches;
	bit                hold_off;

	nice_number_axis_scaler_top #(.DATA_WIDTH(DW), .MAX_TICKS(MAXT)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_min(data_min), .data_max(data_max),
		.out_valid(out_valid), .out_ready(out_ready),
		.tick_mantissa(tick_mantissa), .tick_exponent(tick_exponent),
		.low_tick_index(low_tick_index), .high_tick_index(high_tick_index),
		.order_error(order_error)
	);

	// clock
	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic longint ten_to(input int e);
		longint p;
		p = 1;
		for (int i = 0; i < e; i++) p *= 10;
		return p;
	endfunction

	// nice spacing and tick indices for one range
	function automatic scale_t nice_scale(input logic signed [DW-1:0] mn,
			input logic signed [DW-1:0] mx, input logic [TCFG_W-1:0] tc);
		scale_t  r;
		longint  lo, hi, span, p, bigq, t, den, q;
		int      re, te, s, dp;
		longint  rm, tm;
		lo = mn; hi = mx;
		r = '0;
		if (lo > hi) begin
			r.err = 1'b1;
			return r;
		end
		if (lo == hi) hi = hi + 1;
		span = hi - lo;
		p = 1; re = 0;
		while (p * 10 <= span) begin
			p *= 10; re++;
		end
		if (span <= p) rm = 1;
		else if (span <= 2 * p) rm = 2;
		else if (span <= 5 * p) rm = 5;
		else begin
			rm = 1; re++;
		end
		t = tc;
		if (t < 1) t = 1;
		if (t > MAXT) t = MAXT;
		bigq = rm * ten_to(re + 3);
		p = t; te = -3;
		while (p * 10 <= bigq) begin
			p *= 10; te++;
		end
		if (2 * bigq < 3 * p) tm = 1;
		else if (bigq < 3 * p) tm = 2;
		else if (bigq < 7 * p) tm = 5;
		else begin
			tm = 1; te++;
		end
		s  = te < 0 ? -te : 0;
		dp = te > 0 ? te : 0;
		den = tm * ten_to(dp);
		// floor of the scaled minimum
		q = (lo * ten_to(s)) / den;
		if ((lo * ten_to(s)) % den != 0 && lo < 0) q--;
		r.lo_idx = q[IDX_W-1:0];
		// ceiling of the scaled maximum
		q = (hi * ten_to(s)) / den;
		if ((hi * ten_to(s)) % den != 0 && hi > 0) q++;
		r.hi_idx = q[IDX_W-1:0];
		r.mant = tm[TM_W-1:0];
		r.expo = te[TE_W-1:0];
		return r;
	endfunction

	// send one range as a transaction, valid drops only during an idle gap
	task automatic send_range(input logic signed [DW-1:0] mn,
			input logic signed [DW-1:0] mx);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_min <= mn;
		data_max <= mx;
		scale_q.push_back(nice_scale(mn, mx, ticks_reg));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (scale_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_ticks(input logic [TCFG_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ticks_reg = v;
	endtask

	function automatic logic signed [DW-1:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed(DW'($urandom_range(0, 2000))) - 1000;
			2: return $urandom >> $urandom_range(0, 31);
			default: return -($urandom >> $urandom_range(0, 31));
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [DW-1:0] mx, mn;
		mx = {1'b0, {(DW-1){1'b1}}};
		mn = {1'b1, {(DW-1){1'b0}}};
		send_range(mn, mx);
		send_range(mx, mx);
		send_range(mn, mn);
		send_range(0, 0);
		send_range(-1, -1);
		send_range(mx, mn);
		send_range(5, -5);
		send_range(0, 1);
		send_range(-7, 93);
		send_range(0, 15);
		send_range(0, 30);
		send_range(0, 70);
		send_range(-123456, 987654);
		send_range(mn, 0);
		send_range(0, mx);
		send_range(1, 2);
	endtask

	task automatic test_tick_counts();
		logic [TCFG_W-1:0] counts[6] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd7, 6'd33};
		foreach (counts[i]) begin
			write_ticks(counts[i]);
			send_range(0, 1);
			send_range(-3, 1000);
			send_range({1'b1, {(DW-1){1'b0}}}, {1'b0, {(DW-1){1'b1}}});
			for (int k = 0; k < 30; k++) send_range(rand_word(), rand_word());
		end
	endtask

	task automatic test_random();
		logic signed [DW-1:0] a, b;
		write_ticks(6'($urandom_range(1, 32)));
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) write_ticks(6'($urandom));
			a = rand_word();
			b = rand_word();
			// mostly ordered ranges, some reversed
			if ($urandom_range(0, 9) != 0 && a > b) send_range(b, a);
			else send_range(a, b);
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 120; i++) send_range(rand_word(), rand_word());
	endtask

	// receiver: random stalls plus one long hold-off
	initial begin
		int stall;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			stall = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// result check
	always @(posedge clk) begin
		scale_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{tick_mantissa, tick_exponent, low_tick_index,
				high_tick_index, order_error};
			if (scale_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = scale_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// timeout
	initial begin
		#20ms;
		$display("nice_number_axis_scaler_top test failed");
		$finish;
	end

	initial begin
		mismatches   = 0;
		hold_off     = 1'b0;
		ticks_reg    = 6'd5;
		arst_n       = 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		in_valid     <= 1'b0;
		data_min     <= '0;
		data_max     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_tick_counts();
		test_backpressure();
		test_random();
		drain();
		if (mismatches == 0 && scale_q.size() == 0)
			$display("nice_number_axis_scaler_top test passed");
		else
			$display("nice_number_axis_scaler_top test failed");
		$finish;
	end

endmodule
